### hdl/kerl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kerl_pkg
// Types shared by the rate limiter sequencer and its key table.
// ----------------------------------------------------------------------------
package kerl_pkg;

	localparam int unsigned KEY_W  = 64;
	localparam int unsigned TIME_W = 64;
	localparam int unsigned HOLD_W = 32;
	localparam int unsigned SKIP_W = 32;

	// one stored key with its last pass time and running skip count
	typedef struct packed {
		logic [KEY_W-1:0]  key;
		logic [TIME_W-1:0] last_time;
		logic [SKIP_W-1:0] skips;
	} kerl_entry_t;

	// per-field write enables for the table
	typedef struct packed {
		logic key;
		logic last_time;
		logic skips;
	} kerl_wr_en_t;

endpackage

### hdl/kerl_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kerl_table
// Key table memory: one write port with field enables, one registered read.
// ----------------------------------------------------------------------------
module kerl_table import kerl_pkg::*; #(
	parameter int unsigned DEPTH = 128,
	parameter int unsigned IDX_W = 7
) (
	input  logic             clk,
	input  logic             rd_en,
	input  logic [IDX_W-1:0] rd_addr,
	output kerl_entry_t      rd_data,
	input  kerl_wr_en_t      wr_en,
	input  logic [IDX_W-1:0] wr_addr,
	input  kerl_entry_t      wr_data
);

	logic [KEY_W-1:0]  key_mem  [DEPTH];
	logic [TIME_W-1:0] time_mem [DEPTH];
	logic [SKIP_W-1:0] skip_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en.key) begin
			key_mem[wr_addr] <= wr_data.key;
		end
		if (wr_en.last_time) begin
			time_mem[wr_addr] <= wr_data.last_time;
		end
		if (wr_en.skips) begin
			skip_mem[wr_addr] <= wr_data.skips;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data.key       <= key_mem[rd_addr];
			rd_data.last_time <= time_mem[rd_addr];
			rd_data.skips     <= skip_mem[rd_addr];
		end
	end

endmodule

### hdl/keyed_event_rate_limiter_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_event_rate_limiter_core
// Per-key event rate limiter with an insert-only suppression table.
// ----------------------------------------------------------------------------
// An event request (event_key, current_time, hold_time) is taken on the edge
// where event_valid is high and event_stall is low. Exactly one result
// (passed, skipped_count, not_stored) follows on result_valid, held until a
// cycle with result_stall low.
// The table is scanned in insertion order through one read port, one stored
// key per cycle. The next request can be accepted in the cycle after the
// result is loaded into the output register. event_stall is high while an
// event is being worked on; one finished result may wait in the output
// register while the next event is accepted and scanned, and a stalled
// receiver holds the block only at the point of handing over a new result.
// cfg_we writes throttle_enable (cfg_wdata); the user must write it only
// while the block is idle, as the block does not enforce this.
// Reset clears throttle_enable, the entry count and both valid flags; table
// contents are not cleared, entries beyond the count are never read.
// ----------------------------------------------------------------------------
module keyed_event_rate_limiter_core import kerl_pkg::*; #(
	parameter int unsigned TABLE_ENTRIES = 128
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_wdata,
	input  logic              event_valid,
	output logic              event_stall,
	input  logic [KEY_W-1:0]  event_key,
	input  logic [TIME_W-1:0] current_time,
	input  logic [HOLD_W-1:0] hold_time,
	output logic              result_valid,
	input  logic              result_stall,
	output logic              passed,
	output logic [SKIP_W-1:0] skipped_count,
	output logic              not_stored
);

	localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_SCAN   = 3'd1;
	localparam logic [2:0] ST_DIFF   = 3'd2;
	localparam logic [2:0] ST_DECIDE = 3'd3;
	localparam logic [2:0] ST_EMIT   = 3'd4;

	logic [2:0]        state_q;
	logic              enable_q;
	logic [CNT_W-1:0]  used_q;
	logic [CNT_W-1:0]  issue_idx_q;
	logic [IDX_W-1:0]  cmp_idx_q;
	logic              cmp_vld_q;
	logic [KEY_W-1:0]  key_q;
	logic [TIME_W-1:0] now_q;
	logic [HOLD_W-1:0] hold_q;
	logic [TIME_W-1:0] diff_q;
	logic              res_pass_q;
	logic [SKIP_W-1:0] res_skips_q;
	logic              res_lost_q;
	logic              out_valid_q;
	logic              out_pass_q;
	logic [SKIP_W-1:0] out_skips_q;
	logic              out_lost_q;

	logic              tbl_rd_en;
	kerl_entry_t       tbl_rd_data;
	kerl_wr_en_t       tbl_wr_en;
	logic [IDX_W-1:0]  tbl_wr_addr;
	kerl_entry_t       tbl_wr_data;

	logic              accept;
	logic              hit;
	logic              miss;
	logic              table_full;
	logic              below_hold;
	logic [SKIP_W-1:0] skips_inc;
	logic              out_free;

	assign event_stall = (state_q != ST_IDLE);
	assign accept      = event_valid && (state_q == ST_IDLE);
	assign out_free    = !out_valid_q || !result_stall;

	// a hit is seen on the entry read last cycle; a miss once every entry was compared
	assign hit        = cmp_vld_q && (tbl_rd_data.key == key_q);
	assign miss       = !cmp_vld_q && (issue_idx_q == used_q);
	assign table_full = (used_q == CNT_W'(TABLE_ENTRIES));
	assign below_hold = (diff_q < {{(TIME_W-HOLD_W){1'b0}}, hold_q});
	assign skips_inc  = tbl_rd_data.skips + SKIP_W'(1);

	assign tbl_rd_en = (state_q == ST_SCAN) && !hit && (issue_idx_q != used_q);

	always_comb begin
		tbl_wr_en   = '0;
		tbl_wr_addr = cmp_idx_q;
		tbl_wr_data = '{key: key_q, last_time: now_q, skips: '0};
		case (state_q)
			ST_SCAN: begin
				if (!hit && miss && !table_full) begin
					tbl_wr_en   = '{key: 1'b1, last_time: 1'b1, skips: 1'b1};
					tbl_wr_addr = used_q[IDX_W-1:0];
				end
			end
			ST_DECIDE: begin
				if (below_hold) begin
					tbl_wr_en         = '{key: 1'b0, last_time: 1'b0, skips: 1'b1};
					tbl_wr_data.skips = skips_inc;
				end else begin
					tbl_wr_en = '{key: 1'b0, last_time: 1'b1, skips: 1'b1};
				end
			end
			default: begin
			end
		endcase
	end

	kerl_table #(
		.DEPTH (TABLE_ENTRIES),
		.IDX_W (IDX_W)
	) u_table (
		.clk     (clk),
		.rd_en   (tbl_rd_en),
		.rd_addr (issue_idx_q[IDX_W-1:0]),
		.rd_data (tbl_rd_data),
		.wr_en   (tbl_wr_en),
		.wr_addr (tbl_wr_addr),
		.wr_data (tbl_wr_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
		end else if (cfg_we) begin
			enable_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			used_q      <= '0;
			issue_idx_q <= '0;
			cmp_vld_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						issue_idx_q <= '0;
						cmp_vld_q   <= 1'b0;
						state_q     <= enable_q ? ST_SCAN : ST_EMIT;
					end
				end
				ST_SCAN: begin
					if (hit) begin
						state_q <= ST_DIFF;
					end else if (miss) begin
						if (!table_full) begin
							used_q <= used_q + CNT_W'(1);
						end
						state_q <= ST_EMIT;
					end else begin
						cmp_vld_q <= tbl_rd_en;
						if (tbl_rd_en) begin
							issue_idx_q <= issue_idx_q + CNT_W'(1);
						end
					end
				end
				ST_DIFF: begin
					state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// request payload, compare index and staged result
	always_ff @(posedge clk) begin
		if (accept) begin
			key_q       <= event_key;
			now_q       <= current_time;
			hold_q      <= hold_time;
			res_pass_q  <= 1'b1;
			res_skips_q <= '0;
			res_lost_q  <= 1'b0;
		end
		if (state_q == ST_SCAN) begin
			if (tbl_rd_en) begin
				cmp_idx_q <= issue_idx_q[IDX_W-1:0];
			end
			if (!hit && miss) begin
				res_lost_q <= table_full;
			end
		end
		if (state_q == ST_DIFF) begin
			diff_q <= now_q - tbl_rd_data.last_time;
		end
		if (state_q == ST_DECIDE) begin
			res_pass_q  <= !below_hold;
			res_skips_q <= below_hold ? skips_inc : tbl_rd_data.skips;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_EMIT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT && out_free) begin
			out_pass_q  <= res_pass_q;
			out_skips_q <= res_skips_q;
			out_lost_q  <= res_lost_q;
		end
	end

	assign result_valid  = out_valid_q;
	assign passed        = out_pass_q;
	assign skipped_count = out_skips_q;
	assign not_stored    = out_lost_q;

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the keyed event rate limiter against a cycle-free model of its table.
// Event requests are sent with random gaps on both sides. Each result is
// compared with the model's prediction in order. The run covers throttling
// off and on, the hold window edges, time wrap, zero and maximum hold, and a
// full table.
// ----------------------------------------------------------------------------
module testbench;
	import kerl_pkg::*;

	localparam int unsigned TABLE_ENTRIES = 128;
	localparam int unsigned KEY_POOL = 24;
	localparam int unsigned MAX_REPORTS = 10;

	typedef struct packed {
		logic              passed;
		logic [SKIP_W-1:0] skips;
		logic              lost;
	} limit_result_t;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic              cfg_wdata;
	logic              event_valid;
	logic              event_stall;
	logic [KEY_W-1:0]  event_key;
	logic [TIME_W-1:0] current_time;
	logic [HOLD_W-1:0] hold_time;
	logic              result_valid;
	logic              result_stall;
	logic              passed;
	logic [SKIP_W-1:0] skipped_count;
	logic              not_stored;

	// model of the suppression table
	logic              mdl_throttle;
	int unsigned       mdl_used;
	logic [KEY_W-1:0]  mdl_key   [TABLE_ENTRIES];
	logic [TIME_W-1:0] mdl_last  [TABLE_ENTRIES];
	logic [SKIP_W-1:0] mdl_skips [TABLE_ENTRIES];

	limit_result_t     pending_results[$];
	logic [KEY_W-1:0]  key_pool[KEY_POOL];
	logic [TIME_W-1:0] clock_ms;

	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;
	int unsigned events_sent;
	int unsigned results_seen;
	int unsigned n_passed;
	int unsigned n_suppressed;
	int unsigned n_lost;
	int unsigned mismatch_count;

	keyed_event_rate_limiter_core #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.event_valid  (event_valid),
		.event_stall  (event_stall),
		.event_key    (event_key),
		.current_time (current_time),
		.hold_time    (hold_time),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.passed       (passed),
		.skipped_count(skipped_count),
		.not_stored   (not_stored)
	);

	always #10 clk = ~clk;

	function automatic limit_result_t predict_event(input logic [KEY_W-1:0] key,
			input logic [TIME_W-1:0] now, input logic [HOLD_W-1:0] hold);
		limit_result_t r;
		logic [TIME_W-1:0] elapsed;
		int idx;
		r.passed = 1'b1;
		r.skips = '0;
		r.lost = 1'b0;
		idx = -1;
		if (mdl_throttle) begin
			for (int i = 0; i < mdl_used; i++) begin
				if (idx < 0 && mdl_key[i] == key)
					idx = i;
			end
			if (idx >= 0) begin
				elapsed = now - mdl_last[idx];
				if (elapsed < {32'd0, hold}) begin
					mdl_skips[idx] = mdl_skips[idx] + 1'b1;
					r.skips = mdl_skips[idx];
					r.passed = 1'b0;
				end else begin
					r.skips = mdl_skips[idx];
					mdl_last[idx] = now;
					mdl_skips[idx] = '0;
				end
			end else if (mdl_used < TABLE_ENTRIES) begin
				mdl_key[mdl_used] = key;
				mdl_last[mdl_used] = now;
				mdl_skips[mdl_used] = '0;
				mdl_used++;
			end else begin
				r.lost = 1'b1;
			end
		end
		return r;
	endfunction

	// one event request; valid stays high after acceptance until the next call decides
	task automatic send_event(input logic [KEY_W-1:0] key, input logic [TIME_W-1:0] now,
			input logic [HOLD_W-1:0] hold);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			event_valid <= 1'b0;
			@(negedge clk);
		end
		event_valid  <= 1'b1;
		event_key    <= key;
		current_time <= now;
		hold_time    <= hold;
		do @(posedge clk); while (event_stall);
		pending_results.push_back(predict_event(key, now, hold));
		events_sent++;
	endtask

	task automatic wait_idle();
		@(negedge clk);
		event_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_throttle(input logic value);
		wait_idle();
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we    <= 1'b0;
		mdl_throttle = value;
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// result checker
	always @(posedge clk) begin
		limit_result_t exp_r;
		if (arst_n && result_valid && !result_stall) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS)
					$display("%0t: result with nothing outstanding: passed=%b skips=%0d lost=%b",
						$time, passed, skipped_count, not_stored);
			end else begin
				exp_r = pending_results.pop_front();
				if (passed !== exp_r.passed || skipped_count !== exp_r.skips ||
						not_stored !== exp_r.lost) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS)
						$display("%0t: mismatch: expected passed=%b skips=%0d lost=%b, got passed=%b skips=%0d lost=%b",
							$time, exp_r.passed, exp_r.skips, exp_r.lost,
							passed, skipped_count, not_stored);
				end
				if (exp_r.lost)
					n_lost++;
				else if (exp_r.passed)
					n_passed++;
				else
					n_suppressed++;
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n)
			result_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	task automatic test_throttle_off();
		write_throttle(1'b0);
		send_event('0, '0, '0);
		send_event('1, '1, '1);
		send_event('1, '0, '1);
		send_event(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 32'hAAAA_AAAA);
		send_event(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 32'h5555_5555);
	endtask

	task automatic test_hold_window();
		write_throttle(1'b1);
		send_event('0, 64'd100, 32'd50);  // new key stored
		send_event('0, 64'd120, 32'd50);  // inside window
		send_event('0, 64'd149, 32'd50);  // last time inside the window
		send_event('0, 64'd150, 32'd50);  // elapsed equals hold: passes with count
		send_event('0, 64'd150, 32'd0);   // zero hold always passes
		send_event('0, 64'd150, 32'd0);
	endtask

	task automatic test_time_wrap();
		send_event('1, 64'hFFFF_FFFF_FFFF_FFF0, '1);
		send_event('1, 64'd5, '1);                       // elapsed wraps past zero
		send_event('1, 64'h0000_0000_FFFF_FFEF, '1);     // elapsed equals maximum hold
		send_event('1, 64'h0000_0000_FFFF_FF00, '1);     // time runs backwards
		send_event(64'hAAAA_AAAA_AAAA_AAAA, '0, '0);
		send_event(64'h5555_5555_5555_5555, '1, '1);
		send_event(64'h5555_5555_5555_5555, 64'd2, 32'd4);
	endtask

	task automatic test_random_traffic(input int unsigned n_items, input int unsigned fresh_pct);
		int unsigned r;
		logic [KEY_W-1:0] key;
		logic [HOLD_W-1:0] hold;
		for (int i = 0; i < n_items; i++) begin
			r = $urandom_range(99);
			if (r < 8) begin
				// noise: anything at all
				send_event(rand64(), rand64(), $urandom);
			end else begin
				if (r < 8 + fresh_pct)
					key = rand64();
				else
					key = key_pool[$urandom_range(KEY_POOL - 1)];
				clock_ms = clock_ms + $urandom_range(40);
				r = $urandom_range(99);
				if (r < 5)
					hold = '0;
				else if (r < 10)
					hold = $urandom;
				else
					hold = $urandom_range(120);
				send_event(key, clock_ms, hold);
			end
		end
	endtask

	task automatic test_table_full();
		while (mdl_used < TABLE_ENTRIES)
			send_event(rand64(), rand64(), $urandom);
		// new keys now find no room
		send_event(rand64(), rand64(), $urandom);
		send_event(rand64(), '0, '0);
		send_event(mdl_key[TABLE_ENTRIES - 1], mdl_last[TABLE_ENTRIES - 1], '1);
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 1'b0;
		event_valid = 1'b0;
		event_key = '0;
		current_time = '0;
		hold_time = '0;
		result_stall = 1'b0;
		mdl_throttle = 1'b0;
		mdl_used = 0;
		clock_ms = 64'hFFFF_FFFF_FFFF_F000;
		events_sent = 0;
		results_seen = 0;
		n_passed = 0;
		n_suppressed = 0;
		n_lost = 0;
		mismatch_count = 0;
		send_idle_pct = 27;
		recv_idle_pct = 86;
		for (int i = 0; i < KEY_POOL; i++)
			key_pool[i] = rand64();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_throttle_off();
		test_hold_window();
		test_time_wrap();
		test_random_traffic(230, 5);

		send_idle_pct = 86;
		recv_idle_pct = 27;
		write_throttle(1'b0);
		test_random_traffic(40, 5);
		write_throttle(1'b1);
		test_random_traffic(190, 5);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_table_full();
		test_random_traffic(230, 10);

		wait_idle();
		repeat (200) @(posedge clk);
		mismatch_count += pending_results.size();
		$display("sent %0d events, checked %0d results: %0d passed, %0d suppressed, %0d not stored",
			events_sent, results_seen, n_passed, n_suppressed, n_lost);
		$display("table entries in use at the end: %0d of %0d", mdl_used, TABLE_ENTRIES);
		if (mismatch_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("%0d mismatches", mismatch_count);
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	initial begin
		#30_000_000;
		$display("timeout with %0d results outstanding", pending_results.size());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

### filelist.f
hdl/kerl_pkg.sv
hdl/kerl_table.sv
hdl/keyed_event_rate_limiter_core.sv
tb/sv/testbench.sv
